/* hw/rtl/per_sensor_time_of_day_rebuild_defines.svh */
// Assertion macros for the time of day rebuild block.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef PER_SENSOR_TIME_OF_DAY_REBUILD_DEFINES_SVH
`define PER_SENSOR_TIME_OF_DAY_REBUILD_DEFINES_SVH

// Check that an expression holds at every clock edge out of reset.
`ifndef SYNTH
`define PTOD_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ptod check failed");
`else
`define PTOD_CHECK(lbl, expr)
`endif

// Check that a trigger is followed by a consequence.
`ifndef SYNTH
`define PTOD_IMPLY(lbl, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> cons) \
		else $error("ptod implication failed");
`else
`define PTOD_IMPLY(lbl, trig, cons)
`endif

`endif

/* hw/rtl/ptod_pkg.sv */
package ptod_pkg;

	localparam int TOD_W        = 24;
	localparam int IDX_W        = 16;
	localparam int SENSORS      = 1 << IDX_W;
	localparam int PERIOD_SHIFT = 16;
	localparam int ENTRY_W      = TOD_W + 1;

	localparam logic [TOD_W-1:0] DAY_RESET = 24'd11059200;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// input opcodes
	localparam logic [1:0] OP_REF      = 2'd0;
	localparam logic [1:0] OP_TRUNC    = 2'd1;
	localparam logic [1:0] OP_NO_TRUNC = 2'd2;

	// result status codes
	localparam logic [2:0] ST_REBUILT   = 3'd0;
	localparam logic [2:0] ST_FROM_LAST = 3'd1;
	localparam logic [2:0] ST_CLR_RANGE = 3'd2;
	localparam logic [2:0] ST_CLR_NOREF = 3'd3;
	localparam logic [2:0] ST_UNCHANGED = 3'd4;
	localparam logic [2:0] ST_STORED    = 3'd5;
	localparam logic [2:0] ST_REJECTED  = 3'd6;

	// work class decided by the front
	typedef enum logic [2:0] {
		K_STORE   = 3'd0,
		K_REJECT  = 3'd1,
		K_REBUILD = 3'd2,
		K_LAST    = 3'd3,
		K_NOP     = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [IDX_W-1:0]  idx;
		logic [TOD_W-1:0]  tval;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

/* hw/rtl/ptod_ram.sv */
module ptod_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/ptod_front.sv */
module ptod_front import ptod_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       opcode,
	input  logic [7:0]       sac,
	input  logic [7:0]       sic,
	input  logic [TOD_W-1:0] time_value,
	input  logic             cfg_we,
	input  logic [TOD_W-1:0] cfg_wdata,
	input  logic             clearing,
	input  qstat_t           qstat,
	output logic             busy,
	output logic             push,
	output qent_t            push_data,
	output logic [TOD_W-1:0] day_limit
);

	logic [TOD_W-1:0] day_limit_q;
	kind_t            kind;

	// hold the day limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_limit_q <= DAY_RESET;
		end else if (cfg_we) begin
			day_limit_q <= cfg_wdata;
		end
	end

	// classify the incoming beat; reject late references here
	always_comb begin
		case (opcode)
			OP_REF:      kind = (time_value > day_limit_q) ? K_REJECT : K_STORE;
			OP_TRUNC:    kind = K_REBUILD;
			OP_NO_TRUNC: kind = K_LAST;
			default:     kind = K_NOP;
		endcase
	end

	// stall while the table is cleared or the queue is full
	assign busy = clearing | qstat.full;
	assign push = start & ~busy;

	assign push_data.kind = kind;
	assign push_data.idx  = {sac, sic};
	assign push_data.tval = time_value;
	assign day_limit      = day_limit_q;

endmodule

/* hw/rtl/ptod_queue.sv */
module ptod_queue import ptod_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  qent_t     push_data,
	input  logic      pop,
	output qent_t     head,
	output qstat_t    qstat,
	output logic [QAW:0] count
);

	qent_t          slot_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	// store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head        = slot_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign count       = count_q;

endmodule

/* hw/rtl/ptod_back.sv */
module ptod_back import ptod_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  qent_t            head,
	input  qstat_t           qstat,
	input  logic [TOD_W-1:0] day_limit,
	output logic             pop,
	output logic             clearing,
	output logic             done,
	output logic [2:0]       status,
	output logic [TOD_W-1:0] tod_out
);

	typedef enum logic [1:0] {
		B_CLEAR = 2'b01,
		B_RUN   = 2'b10
	} bstate_t;

	bstate_t            state_q;
	logic [IDX_W-1:0]   clr_addr_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               valid_s1;
	kind_t              kind_s1;
	logic [TOD_W-1:0]   tval_s1;

	logic               done_q;
	logic [2:0]         status_q;
	logic [TOD_W-1:0]   tod_q;

	logic               rec_valid;
	logic [TOD_W-1:0]   rec_tod;
	logic [TOD_W-1:0]   base;
	logic [TOD_W:0]     sum;
	logic               out_of_range;
	logic [2:0]         st_next;
	logic [TOD_W-1:0]   tod_next;

	// sweep the table once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				B_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= B_RUN;
					end
				end
				B_RUN:   state_q <= B_RUN;
				default: state_q <= B_CLEAR;
			endcase
		end
	end

	assign clearing = (state_q != B_RUN);
	assign pop      = ~clearing & ~qstat.empty;

	// drive the table write port: clear pass, else reference store
	always_comb begin
		if (clearing) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = pop & (head.kind == K_STORE);
			ram_waddr = head.idx;
			ram_wdata = {1'b1, head.tval};
		end
	end

	ptod_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SENSORS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head.idx),
		.rdata (ram_rdata)
	);

	// capture the popped beat alongside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= head.kind;
			tval_s1 <= head.tval;
		end
	end

	// rebuild the full time from the period base
	assign rec_valid    = ram_rdata[ENTRY_W-1];
	assign rec_tod      = ram_rdata[TOD_W-1:0];
	assign base         = {rec_tod[TOD_W-1:PERIOD_SHIFT], {PERIOD_SHIFT{1'b0}}};
	assign sum          = {1'b0, tval_s1} + {1'b0, base};
	assign out_of_range = (tval_s1 >= day_limit) | (base >= day_limit)
	                    | (sum >= {1'b0, day_limit});

	always_comb begin
		st_next  = ST_UNCHANGED;
		tod_next = '0;
		case (kind_s1)
			K_STORE:  st_next = ST_STORED;
			K_REJECT: st_next = ST_REJECTED;
			K_REBUILD: begin
				if (!rec_valid) begin
					st_next = ST_CLR_NOREF;
				end else if (out_of_range) begin
					st_next = ST_CLR_RANGE;
				end else begin
					st_next  = ST_REBUILT;
					tod_next = sum[TOD_W-1:0];
				end
			end
			K_LAST: begin
				if (rec_valid) begin
					st_next  = ST_FROM_LAST;
					tod_next = rec_tod;
				end
			end
			default: st_next = ST_UNCHANGED;
		endcase
	end

	// register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= st_next;
			tod_q    <= tod_next;
		end
	end

	assign done    = done_q;
	assign status  = status_q;
	assign tod_out = tod_q;

endmodule

/* hw/rtl/per_sensor_time_of_day_rebuild.sv */
// Per-sensor time of day rebuild.
// Input: a command beat (opcode, sac, sic, time_value) is taken at a rising
// edge with start high and busy low. Every command gives one result beat.
// Output: done is high for one cycle per result, with status and tod_out valid; the
// receiver has no way to hold results off and none is needed.
// Configuration: cfg_we writes cfg_wdata into the day limit register; write
// it only while no command is in flight.
// Result path: each command passes the queue, the table read and the result
// register in that order; no command waits in the queue behind another.
// Throughput: one command per cycle outside the reset sweep; the one table
// read and at most one table write per command set it; the queue never fills.
// Reset: arst_n clears the control state and loads the day limit default,
// then the sensor table is swept to zero, one entry per cycle, which keeps
// busy high until all 65536 entries are cleared.
`include "per_sensor_time_of_day_rebuild_defines.svh"

module per_sensor_time_of_day_rebuild import ptod_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [7:0]       sac,
	input  logic [7:0]       sic,
	input  logic [TOD_W-1:0] time_value,
	input  logic             cfg_we,
	input  logic [TOD_W-1:0] cfg_wdata,
	output logic             done,
	output logic [2:0]       status,
	output logic [TOD_W-1:0] tod_out
);

	logic             push;
	qent_t            push_data;
	logic             pop;
	qent_t            head;
	qstat_t           qstat;
	logic [QAW:0]     q_count;
	logic             clearing;
	logic [TOD_W-1:0] day_limit;

	ptod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.sac        (sac),
		.sic        (sic),
		.time_value (time_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.clearing   (clearing),
		.qstat      (qstat),
		.busy       (busy),
		.push       (push),
		.push_data  (push_data),
		.day_limit  (day_limit)
	);

	ptod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat),
		.count     (q_count)
	);

	ptod_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.day_limit (day_limit),
		.pop       (pop),
		.clearing  (clearing),
		.done      (done),
		.status    (status),
		.tod_out   (tod_out)
	);

	// every taken command returns a result, and each result has a taken command
	`PTOD_IMPLY(a_cmd_returns, start && !busy, ##3 done)
	`PTOD_IMPLY(a_no_spurious_done, done, $past(start && !busy, 3))
	// after the table sweep the back drains every cycle, so the queue never backs up
	`PTOD_CHECK(a_queue_shallow, q_count <= 1)
	// only rebuilt and last-reference results carry a time
	`PTOD_IMPLY(a_tod_zero, done && status != ST_REBUILT && status != ST_FROM_LAST,
		tod_out == '0)

endmodule

/* bench/tod_rebuild_checker.sv */
import ptod_pkg::*;

module tod_rebuild_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [1:0]       opcode,
	input  logic [7:0]       sac,
	input  logic [7:0]       sic,
	input  logic [TOD_W-1:0] time_value,
	input  logic             cfg_we,
	input  logic [TOD_W-1:0] cfg_wdata,
	input  logic             done,
	input  logic [2:0]       status,
	input  logic [TOD_W-1:0] tod_out,
	output int               mismatch_cnt,
	output int               pending_cnt
);

	localparam int BASE_W = TOD_W - PERIOD_SHIFT;

	typedef struct packed {
		logic [2:0]       status;
		logic [TOD_W-1:0] tod;
	} tod_result_t;

	// per-sensor reference store
	logic              ref_known   [SENSORS];
	logic [BASE_W-1:0] ref_base_hi [SENSORS];
	logic [TOD_W-1:0]  ref_tod     [SENSORS];
	logic [TOD_W-1:0]  day_limit;

	tod_result_t tod_expect_q [$];

	// Work out the result of one command and update the store.
	function automatic tod_result_t predict_tod(input logic [1:0] op,
			input logic [IDX_W-1:0] idx, input logic [TOD_W-1:0] t);
		tod_result_t      res;
		logic [TOD_W-1:0] base;
		logic [TOD_W:0]   sum;
		res = '{status: ST_UNCHANGED, tod: '0};
		case (op)
			OP_REF: begin
				if (t > day_limit) begin
					res.status = ST_REJECTED;
				end else begin
					ref_tod[idx]     = t;
					ref_base_hi[idx] = BASE_W'(t >> PERIOD_SHIFT);
					ref_known[idx]   = 1'b1;
					res.status       = ST_STORED;
				end
			end
			OP_TRUNC: begin
				if (!ref_known[idx]) begin
					res.status = ST_CLR_NOREF;
				end else begin
					base = TOD_W'(ref_base_hi[idx]) << PERIOD_SHIFT;
					sum  = {1'b0, t} + {1'b0, base};
					if (t >= day_limit || base >= day_limit || sum >= {1'b0, day_limit}) begin
						res.status = ST_CLR_RANGE;
					end else begin
						res.status = ST_REBUILT;
						res.tod    = sum[TOD_W-1:0];
					end
				end
			end
			OP_NO_TRUNC: begin
				if (ref_known[idx]) begin
					res.status = ST_FROM_LAST;
					res.tod    = ref_tod[idx];
				end
			end
			default: res.status = ST_UNCHANGED;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tod_result_t want;
		tod_result_t pred;
		if (!arst_n) begin
			day_limit = DAY_RESET;
			for (int i = 0; i < SENSORS; i++)
				ref_known[i] = 1'b0;
			tod_expect_q.delete();
			mismatch_cnt = 0;
			pending_cnt <= 0;
		end else begin
			// compare the result beat against the oldest expectation
			if (done) begin
				if (tod_expect_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d tod %0d",
						$time, status, tod_out);
					mismatch_cnt++;
				end else begin
					want = tod_expect_q.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						mismatch_cnt++;
					end
					if (tod_out !== want.tod) begin
						$display("%0t: tod_out expected %0d actual %0d",
							$time, want.tod, tod_out);
						mismatch_cnt++;
					end
				end
			end
			// predict each accepted command beat
			if (start && !busy) begin
				pred         = predict_tod(opcode, {sac, sic}, time_value);
				tod_expect_q = {tod_expect_q, pred};
			end
			// track the day limit register
			if (cfg_we)
				day_limit = cfg_wdata;
			pending_cnt <= tod_expect_q.size();
		end
	end

endmodule

/* bench/per_sensor_time_of_day_rebuild_tb.sv */
import ptod_pkg::*;

module per_sensor_time_of_day_rebuild_tb;

	localparam logic [1:0]       OP_UNUSED  = 2'd3;
	localparam logic [TOD_W-1:0] TOD_MAX    = '1;
	localparam int               IDLE_LIMIT = 300000;
	localparam int               PHASES     = 8;
	localparam int               PHASE_CMDS = 150;
	localparam int               POOL_SIZE  = 6;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       opcode;
	logic [7:0]       sac;
	logic [7:0]       sic;
	logic [TOD_W-1:0] time_value;
	logic             cfg_we;
	logic [TOD_W-1:0] cfg_wdata;
	logic             done;
	logic [2:0]       status;
	logic [TOD_W-1:0] tod_out;
	int               mismatch_cnt;
	int               pending_cnt;
	int               stall_cycles = 0;

	logic             gaps_on;
	logic [TOD_W-1:0] cur_limit;
	logic [IDX_W-1:0] sensor_pool [POOL_SIZE];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	per_sensor_time_of_day_rebuild dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.sac        (sac),
		.sic        (sic),
		.time_value (time_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.status     (status),
		.tod_out    (tod_out)
	);

	tod_rebuild_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.sac          (sac),
		.sic          (sic),
		.time_value   (time_value),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.status       (status),
		.tod_out      (tod_out),
		.mismatch_cnt (mismatch_cnt),
		.pending_cnt  (pending_cnt)
	);

	// Abort when no beat moves for too long; covers the table sweep after reset.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Drive one command beat after an optional gap and hold it until taken.
	task automatic issue_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input logic [TOD_W-1:0] t);
		int gap;
		gap = gaps_on ? (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		opcode     <= op;
		sac        <= idx[15:8];
		sic        <= idx[7:0];
		time_value <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start and wait until every expected result is back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
	endtask

	task automatic set_day_limit(input logic [TOD_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		cur_limit  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a time value that lands near the interesting boundaries.
	function automatic logic [TOD_W-1:0] pick_time(input logic [1:0] op);
		logic [TOD_W-1:0] t;
		t = TOD_W'($urandom);
		if (op == OP_REF) begin
			case ($urandom_range(0, 5))
				0, 1, 2: t = TOD_W'($urandom_range(0, cur_limit));
				3:       t = cur_limit;
				4:       t = (cur_limit == TOD_MAX) ? TOD_MAX : cur_limit + 1'b1;
				default: ;
			endcase
		end else if (op == OP_TRUNC) begin
			case ($urandom_range(0, 5))
				0, 1, 2: t = TOD_W'($urandom_range(0, (1 << PERIOD_SHIFT) - 1));
				3:       t = cur_limit - TOD_W'($urandom_range(0, 2));
				4:       t = TOD_W'($urandom_range(0, cur_limit));
				default: ;
			endcase
		end
		return t;
	endfunction

	initial begin
		logic [TOD_W-1:0] phase_limit [PHASES];
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		int               pick;

		arst_n     = 1'b0;
		start      = 1'b0;
		opcode     = OP_REF;
		sac        = '0;
		sic        = '0;
		time_value = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		gaps_on    = 1'b1;
		cur_limit  = DAY_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// hold off until the table sweep has finished
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed: unknown sensors, unused opcode, limits of the default day
		issue_cmd(OP_NO_TRUNC, 16'h0000, '0);
		issue_cmd(OP_TRUNC, 16'h0000, '0);
		issue_cmd(OP_UNUSED, 16'hFFFF, TOD_MAX);
		issue_cmd(OP_REF, 16'hFFFF, DAY_RESET);
		issue_cmd(OP_REF, 16'hFFFF, DAY_RESET + 1'b1);
		issue_cmd(OP_NO_TRUNC, 16'hFFFF, '0);
		issue_cmd(OP_TRUNC, 16'hFFFF, '0);
		issue_cmd(OP_TRUNC, 16'hFFFF, 24'd49151);
		issue_cmd(OP_TRUNC, 16'hFFFF, 24'd49152);
		issue_cmd(OP_TRUNC, 16'hFFFF, TOD_MAX);
		issue_cmd(OP_REF, 16'h0000, '0);
		issue_cmd(OP_TRUNC, 16'h0000, '0);
		issue_cmd(OP_REF, 16'h0000, TOD_MAX);
		issue_cmd(OP_NO_TRUNC, 16'h0000, '0);
		issue_cmd(OP_REF, 16'hA55A, 24'h123456);
		issue_cmd(OP_TRUNC, 16'hA55A, 24'h00FFFF);
		issue_cmd(OP_NO_TRUNC, 16'h5AA5, '0);
		// zero day limit: only time zero is stored, every rebuild is out of range
		set_day_limit('0);
		issue_cmd(OP_REF, 16'h0101, '0);
		issue_cmd(OP_REF, 16'h0102, 24'd1);
		issue_cmd(OP_TRUNC, 16'h0101, '0);
		// widest day
		set_day_limit(TOD_MAX);
		issue_cmd(OP_REF, 16'h0203, TOD_MAX);
		issue_cmd(OP_TRUNC, 16'h0203, 24'h00FFFF);
		issue_cmd(OP_TRUNC, 16'h0203, 24'h00FFFE);
		// stored base now beyond the limit
		set_day_limit(24'h010000);
		issue_cmd(OP_TRUNC, 16'h0203, '0);

		// random phases, each with its own limit and sensor pool
		phase_limit[0] = DAY_RESET;
		phase_limit[1] = TOD_W'($urandom_range(1, TOD_MAX));
		phase_limit[2] = TOD_MAX;
		phase_limit[3] = 24'd1;
		phase_limit[4] = TOD_W'($urandom_range(65536, 262144));
		phase_limit[5] = '0;
		phase_limit[6] = TOD_W'($urandom_range(1, TOD_MAX));
		phase_limit[7] = DAY_RESET;
		for (int p = 0; p < PHASES; p++) begin
			set_day_limit(phase_limit[p]);
			gaps_on = ($urandom_range(0, 3) != 0);
			for (int s = 0; s < POOL_SIZE; s++)
				sensor_pool[s] = IDX_W'($urandom);
			for (int n = 0; n < PHASE_CMDS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					// noise: any opcode, any sensor
					op  = 2'($urandom);
					idx = IDX_W'($urandom);
				end else begin
					idx  = sensor_pool[$urandom_range(0, POOL_SIZE - 1)];
					pick = $urandom_range(0, 99);
					if (pick < 30)
						op = OP_REF;
					else if (pick < 70)
						op = OP_TRUNC;
					else if (pick < 95)
						op = OP_NO_TRUNC;
					else
						op = OP_UNUSED;
				end
				issue_cmd(op, idx, pick_time(op));
			end
		end

		// drain and settle before the verdict
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
